/* src/psed_pkg.sv */
// Shared types and constants for the pendulum swing event detector.
package psed_pkg;

   localparam int unsigned CFG_WIDTH   = 15;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned ANGLE_W     = 16;
   localparam int unsigned VEL_W       = 16;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned KIND_W      = 3;
   localparam int unsigned REQ_DATA_W  = 64;
   localparam int unsigned RSP_DATA_W  = 64;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] DOWN_REARM_RESET = 15'd819;
   localparam logic [CFG_WIDTH-1:0] PEAK_ANGLE_RESET = 15'd410;
   localparam logic [CFG_WIDTH-1:0] PEAK_SPEED_RESET = 15'd128;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOWN_REARM = 2'd0,
      CSR_PEAK_ANGLE = 2'd1,
      CSR_PEAK_SPEED = 2'd2
   } csr_index_type;

   // Event codes carried on rsp_tuser
   typedef enum logic [KIND_W-1:0] {
      EV_NONE     = 3'd0,
      EV_DOWN_POS = 3'd1,
      EV_DOWN_NEG = 3'd2,
      EV_PEAK_POS = 3'd3,
      EV_PEAK_NEG = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] down_rearm;
      logic [CFG_WIDTH-1:0] peak_angle;
      logic [CFG_WIDTH-1:0] peak_speed;
   } cfg_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [VEL_W-1:0]   velocity;
      logic [TIME_W-1:0]         time_us;
   } sample_type;

   typedef struct packed {
      event_kind_type            kind;
      logic [TIME_W-1:0]         time_us;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [VEL_W-1:0]   velocity;
   } event_type;

endpackage

/* src/psed_csr.sv */
// Threshold registers written through the csr port.
module psed_csr import psed_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DOWN_REARM: cfg_in.down_rearm = csr_wdata;
            CSR_PEAK_ANGLE: cfg_in.peak_angle = csr_wdata;
            CSR_PEAK_SPEED: cfg_in.peak_speed = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.down_rearm <= DOWN_REARM_RESET;
         cfg_ff.peak_angle <= PEAK_ANGLE_RESET;
         cfg_ff.peak_speed <= PEAK_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/psed_core.sv */
// Swing state and prioritized event decision for one sample.
module psed_core import psed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  sample_type sample,
   input  cfg_type    cfg,
   output event_type  evt
);

   logic                      down_pos_ff, down_pos_in;
   logic                      down_neg_ff, down_neg_in;
   logic                      peak_pos_ff, peak_pos_in;
   logic                      peak_neg_ff, peak_neg_in;
   logic signed [ANGLE_W-1:0] pos_angle_ff, pos_angle_in;
   logic signed [ANGLE_W-1:0] neg_angle_ff, neg_angle_in;
   logic [TIME_W-1:0]         pos_time_ff, pos_time_in;
   logic [TIME_W-1:0]         neg_time_ff, neg_time_in;

   logic signed [ANGLE_W:0]   a_x, w_x;
   logic signed [ANGLE_W:0]   rearm_x, pmin_x, pspd_x;
   logic                      dpa, dna;
   logic                      fire_dpos, fire_dneg, fire_ppos, fire_pneg;
   logic                      pos_cond, neg_cond, pos_upd, neg_upd;
   logic                      ppa, pna;
   logic signed [ANGLE_W-1:0] pos_angle_mid, neg_angle_mid;
   logic [TIME_W-1:0]         pos_time_mid, neg_time_mid;

   // Widen everything to 17-bit signed for the compares
   assign a_x     = {sample.angle[ANGLE_W-1], sample.angle};
   assign w_x     = {sample.velocity[VEL_W-1], sample.velocity};
   assign rearm_x = signed'({2'b00, cfg.down_rearm});
   assign pmin_x  = signed'({2'b00, cfg.peak_angle});
   assign pspd_x  = signed'({2'b00, cfg.peak_speed});

   // Re-arm the down crossings, then check them in priority order
   always_comb begin
      dpa       = down_pos_ff | (a_x <= -rearm_x);
      dna       = down_neg_ff | (a_x >= rearm_x);
      fire_dpos = dpa && (a_x >= 0) && (w_x > 0);
      fire_dneg = !fire_dpos && dna && (a_x <= 0) && (w_x < 0);
   end

   // Track the positive peak; skipped when a down crossing fired
   always_comb begin
      pos_cond      = !fire_dpos && !fire_dneg && (a_x >= pmin_x) && (w_x >= pspd_x);
      pos_upd       = pos_cond && (!peak_pos_ff || (sample.angle > pos_angle_ff));
      ppa           = peak_pos_ff | pos_cond;
      pos_angle_mid = pos_upd ? sample.angle : pos_angle_ff;
      pos_time_mid  = pos_upd ? sample.time_us : pos_time_ff;
      fire_ppos     = !fire_dpos && !fire_dneg && ppa && (w_x <= 0);
   end

   // Track the negative peak; skipped when any earlier check fired
   always_comb begin
      neg_cond      = !fire_dpos && !fire_dneg && !fire_ppos
                      && (a_x <= -pmin_x) && (w_x <= -pspd_x);
      neg_upd       = neg_cond && (!peak_neg_ff || (sample.angle < neg_angle_ff));
      pna           = peak_neg_ff | neg_cond;
      neg_angle_mid = neg_upd ? sample.angle : neg_angle_ff;
      neg_time_mid  = neg_upd ? sample.time_us : neg_time_ff;
      fire_pneg     = !fire_dpos && !fire_dneg && !fire_ppos && pna && (w_x >= 0);
   end

   // Next state: hold unless a sample moves through
   always_comb begin
      down_pos_in  = down_pos_ff;
      down_neg_in  = down_neg_ff;
      peak_pos_in  = peak_pos_ff;
      peak_neg_in  = peak_neg_ff;
      pos_angle_in = pos_angle_ff;
      neg_angle_in = neg_angle_ff;
      pos_time_in  = pos_time_ff;
      neg_time_in  = neg_time_ff;
      if (advance) begin
         down_pos_in  = dpa && !fire_dpos;
         down_neg_in  = dna && !fire_dneg;
         peak_pos_in  = ppa && !fire_ppos;
         peak_neg_in  = pna && !fire_pneg;
         pos_angle_in = pos_angle_mid;
         neg_angle_in = neg_angle_mid;
         pos_time_in  = pos_time_mid;
         neg_time_in  = neg_time_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_pos_ff  <= 1'b0;
         down_neg_ff  <= 1'b0;
         peak_pos_ff  <= 1'b0;
         peak_neg_ff  <= 1'b0;
         pos_angle_ff <= '0;
         neg_angle_ff <= '0;
         pos_time_ff  <= '0;
         neg_time_ff  <= '0;
      end else begin
         down_pos_ff  <= down_pos_in;
         down_neg_ff  <= down_neg_in;
         peak_pos_ff  <= peak_pos_in;
         peak_neg_ff  <= peak_neg_in;
         pos_angle_ff <= pos_angle_in;
         neg_angle_ff <= neg_angle_in;
         pos_time_ff  <= pos_time_in;
         neg_time_ff  <= neg_time_in;
      end
   end

   // Select the result word
   always_comb begin
      evt = '0;
      priority if (fire_dpos) begin
         evt.kind     = EV_DOWN_POS;
         evt.time_us  = sample.time_us;
         evt.angle    = sample.angle;
         evt.velocity = sample.velocity;
      end else if (fire_dneg) begin
         evt.kind     = EV_DOWN_NEG;
         evt.time_us  = sample.time_us;
         evt.angle    = sample.angle;
         evt.velocity = sample.velocity;
      end else if (fire_ppos) begin
         evt.kind     = EV_PEAK_POS;
         evt.time_us  = pos_time_mid;
         evt.angle    = pos_angle_mid;
      end else if (fire_pneg) begin
         evt.kind     = EV_PEAK_NEG;
         evt.time_us  = neg_time_mid;
         evt.angle    = neg_angle_mid;
      end else begin
         evt.kind     = EV_NONE;
      end
   end

endmodule

/* src/pendulum_swing_event_detector_top.sv */
// Top level of the pendulum swing event detector: input and result registers.
//
//  channel | direction | handshake              | contents
//  req     | in        | req_tvalid/req_tready  | one sample word
//  rsp     | out       | rsp_tvalid/rsp_tready  | one event word per sample
//  csr     | in        | csr_we                 | threshold register write
//
// A sample is held in the input register, where the swing state is updated
// and the event chosen, then moves to the result register, which drives
// rsp_tvalid; a stalled result register keeps the sample in the input
// register. One word per cycle is sustained while rsp_tready stays high.
// The two registers form a pipeline; req_tready drops only when both are
// full and rsp_tready is low. Synchronous reset empties both stages, clears
// the swing state and loads the threshold defaults.
module pendulum_swing_event_detector_top import psed_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // angle [15:0], velocity [31:16], time_us [63:32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // event_time [31:0], event_angle [47:32], event_velocity [63:48]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // event_kind [2:0]
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_WIDTH-1:0]  csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   sample_type in_data_ff;
   logic       out_valid_ff, out_valid_in;
   event_type  out_data_ff;
   logic       out_open, advance;
   cfg_type    cfg;
   event_type  evt;

   psed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psed_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_data_ff),
      .cfg     (cfg),
      .evt     (evt)
   );

   // Pipeline flow control
   assign out_open   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || out_open;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = out_open ? in_valid_ff : out_valid_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load a word when the stage opens
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff.angle    <= req_tdata[15:0];
         in_data_ff.velocity <= req_tdata[31:16];
         in_data_ff.time_us  <= req_tdata[63:32];
      end
      if (advance) begin
         out_data_ff <= evt;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.kind;
   assign rsp_tdata  = {out_data_ff.velocity, out_data_ff.angle, out_data_ff.time_us};

endmodule

/* src/psed_checker.sv */
// Port-level checks for the pendulum swing event detector, bound to the top.
module psed_checker import psed_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]     rsp_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // A word with no event carries all-zero data
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_NONE) |-> (rsp_tdata == '0))
      else $error("no-event word carries nonzero data");

   // Peak events report zero velocity
   a_peak_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == EV_PEAK_POS || rsp_tuser == EV_PEAK_NEG))
      |-> (rsp_tdata[63:48] == '0))
      else $error("peak event with nonzero velocity");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   // An open result side keeps the input side open
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while result side is open");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind pendulum_swing_event_detector_top psed_checker u_psed_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
